### rtl/roman_numerals_of_value_and_primes_top_defines.svh
// Assertion macros shared by the checker of the Roman numeral block.
// Depends on nothing; included by the files that hold assertions.
`ifndef ROMAN_NUMERALS_OF_VALUE_AND_PRIMES_TOP_DEFINES_SVH
`define ROMAN_NUMERALS_OF_VALUE_AND_PRIMES_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define RNP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RNP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rnp_pkg.sv
// Package of the Roman numeral and prime search block: types, codes and the weight table.
// Used by the remainder unit, the top level and the checker.
package rnp_pkg;

  localparam int IN_W    = 16;
  localparam int VAL_W   = 12;
  localparam int SQ_W    = VAL_W + 1;
  localparam int CNT_W   = $clog2(VAL_W + 1);
  localparam int NUM_PRIMES = 3;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [3:0]       sym_t;
  typedef logic [1:0]       which_t;

  localparam logic [IN_W-1:0] VAL_MIN = 16'd6;
  localparam logic [IN_W-1:0] VAL_MAX = 16'd3999;

  localparam sym_t   SYM_I        = 4'd12;
  localparam sym_t   SYM_LINE_END = 4'd13;
  localparam sym_t   SYM_STOP     = 4'd14;
  localparam which_t WHICH_VALUE  = 2'd0;
  localparam which_t WHICH_LAST   = 2'd3;
  localparam logic [1:0] PRIME_LAST = 2'(NUM_PRIMES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } state_t;

  // Request to and response from the shared remainder unit.
  typedef struct packed {
    logic start;
    val_t dividend;
    val_t divisor;
  } rem_req_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } rem_rsp_t;

  // Value of each symbol code, from M down to I.
  function automatic val_t weight(input sym_t idx);
    val_t w;
    case (idx)
      4'd0:    w = 12'd1000;
      4'd1:    w = 12'd900;
      4'd2:    w = 12'd500;
      4'd3:    w = 12'd400;
      4'd4:    w = 12'd100;
      4'd5:    w = 12'd90;
      4'd6:    w = 12'd50;
      4'd7:    w = 12'd40;
      4'd8:    w = 12'd10;
      4'd9:    w = 12'd9;
      4'd10:   w = 12'd5;
      4'd11:   w = 12'd4;
      default: w = 12'd1;
    endcase
    return w;
  endfunction

endpackage

### rtl/rnp_rem_unit.sv
// Restoring remainder unit, one dividend bit per cycle.
// Depends on rnp_pkg for the request and response structs.
module rnp_rem_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  rnp_pkg::rem_req_t req,
  output rnp_pkg::rem_rsp_t rsp
);
  import rnp_pkg::*;

  logic             run_r, run_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  val_t             dvd_r, dvd_nxt;
  val_t             dvs_r, dvs_nxt;
  val_t             rem_r, rem_nxt;
  logic [SQ_W-1:0]  shifted;

  assign shifted = {rem_r, dvd_r[VAL_W-1]};

  always_comb begin
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    dvd_nxt = dvd_r;
    dvs_nxt = dvs_r;
    rem_nxt = rem_r;
    if (req.start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(VAL_W);
      dvd_nxt = req.dividend;
      dvs_nxt = req.divisor;
      rem_nxt = '0;
    end else if (run_r) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 1'b1;
        dvd_nxt = {dvd_r[VAL_W-2:0], 1'b0};
        if (shifted >= {1'b0, dvs_r}) begin
          rem_nxt = VAL_W'(shifted - {1'b0, dvs_r});
        end else begin
          rem_nxt = shifted[VAL_W-1:0];
        end
      end else begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done     = run_r && (cnt_r == '0);
  assign rsp.rem_zero = (rem_r == '0);

endmodule

### rtl/roman_numerals_of_value_and_primes_top.sv
// Top level of the Roman numeral block: sequencer, prime search and numeral emission.
// Depends on rnp_pkg and rnp_rem_unit.
//
// Use: drive in_value and raise start while busy is low; that edge accepts the item.
// A value from 6 to 3999 makes the block busy. It searches downward for the three
// largest primes below the value by trial division, then sends the numeral of the
// value and of each prime as symbol tokens, each numeral closed by a line end.
// Every token is shown on out_symbol, out_which_number and out_last for one cycle
// with out_strobe high; out_last marks the final token of the item.
// Any other value gives one stop token in the cycle after acceptance and the
// block stays ready.
// Each trial divisor takes a check state and then a division in the shared bit-serial
// remainder unit; each of the three primes found takes a further check state. In
// emission each step either sends a token or skips a weight. The shared remainder
// unit sets the rate.
// The receiver cannot stall; tokens are never held back.
// Reset (synchronous, rst_n low) returns the block to idle and drops out_strobe.
module roman_numerals_of_value_and_primes_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [rnp_pkg::IN_W-1:0] in_value,
  output logic                     out_strobe,
  output logic [3:0]               out_symbol,
  output logic [1:0]               out_which_number,
  output logic                     out_last
);
  import rnp_pkg::*;

  state_t          state_r, state_nxt;
  val_t            cand_r, cand_nxt;
  val_t            div_r, div_nxt;
  logic [SQ_W-1:0] sq_r, sq_nxt;
  logic [1:0]      nprime_r, nprime_nxt;
  val_t            found_r [NUM_PRIMES];
  logic            found_we;
  val_t            rem_val_r, rem_val_nxt;
  sym_t            idx_r, idx_nxt;
  which_t          which_r, which_nxt;
  logic            strobe_r, strobe_nxt;
  sym_t            sym_r, sym_nxt;
  which_t          outw_r, outw_nxt;
  logic            last_r, last_nxt;
  rem_req_t        req;
  rem_rsp_t        rsp;
  logic            accept;
  logic            in_range;
  logic            prime_done;
  val_t            w_cur;

  rnp_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign accept     = start && !busy;
  assign in_range   = (in_value >= VAL_MIN) && (in_value <= VAL_MAX);
  // The candidate is prime once the divisor squared passes it.
  assign prime_done = (cand_r < 12'd2) || (sq_r > {1'b0, cand_r});
  assign w_cur      = weight(idx_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_range) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!prime_done) begin
          state_nxt = ST_DIV;
        end else if (nprime_r == PRIME_LAST) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (rsp.done) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_EMIT: begin
        if (rem_val_r == '0 && which_r == WHICH_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cand_nxt     = cand_r;
    div_nxt      = div_r;
    sq_nxt       = sq_r;
    nprime_nxt   = nprime_r;
    found_we     = 1'b0;
    rem_val_nxt  = rem_val_r;
    idx_nxt      = idx_r;
    which_nxt    = which_r;
    strobe_nxt   = 1'b0;
    sym_nxt      = sym_r;
    outw_nxt     = outw_r;
    last_nxt     = 1'b0;
    req.start    = 1'b0;
    req.dividend = cand_r;
    req.divisor  = div_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_range) begin
            cand_nxt    = VAL_W'(in_value - 1'b1);
            div_nxt     = 12'd2;
            sq_nxt      = 13'd4;
            nprime_nxt  = '0;
            rem_val_nxt = in_value[VAL_W-1:0];
          end else begin
            strobe_nxt = 1'b1;
            sym_nxt    = SYM_STOP;
            outw_nxt   = WHICH_VALUE;
            last_nxt   = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (prime_done) begin
          found_we   = 1'b1;
          cand_nxt   = (cand_r == '0) ? cand_r : cand_r - 1'b1;
          div_nxt    = 12'd2;
          sq_nxt     = 13'd4;
          nprime_nxt = nprime_r + 1'b1;
          idx_nxt    = '0;
          which_nxt  = WHICH_VALUE;
        end else begin
          req.start = 1'b1;
        end
      end
      ST_DIV: begin
        if (rsp.done) begin
          if (rsp.rem_zero) begin
            cand_nxt = cand_r - 1'b1;
            div_nxt  = 12'd2;
            sq_nxt   = 13'd4;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            div_nxt = div_r + 1'b1;
            sq_nxt  = sq_r + {div_r, 1'b1};
          end
        end
      end
      ST_EMIT: begin
        if (rem_val_r != '0) begin
          if (rem_val_r >= w_cur) begin
            strobe_nxt  = 1'b1;
            sym_nxt     = idx_r;
            outw_nxt    = which_r;
            rem_val_nxt = rem_val_r - w_cur;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          strobe_nxt = 1'b1;
          sym_nxt    = SYM_LINE_END;
          outw_nxt   = which_r;
          last_nxt   = (which_r == WHICH_LAST);
          if (which_r != WHICH_LAST) begin
            rem_val_nxt = found_r[which_r];
            which_nxt   = which_r + 1'b1;
            idx_nxt     = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      strobe_r  <= 1'b0;
      cand_r    <= '0;
      div_r     <= '0;
      sq_r      <= '0;
      nprime_r  <= '0;
      rem_val_r <= '0;
      idx_r     <= '0;
      which_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      strobe_r  <= strobe_nxt;
      cand_r    <= cand_nxt;
      div_r     <= div_nxt;
      sq_r      <= sq_nxt;
      nprime_r  <= nprime_nxt;
      rem_val_r <= rem_val_nxt;
      idx_r     <= idx_nxt;
      which_r   <= which_nxt;
    end
    sym_r  <= sym_nxt;
    outw_r <= outw_nxt;
    last_r <= last_nxt;
    if (found_we) begin
      found_r[nprime_r] <= cand_r;
    end
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_strobe       = strobe_r;
  assign out_symbol       = sym_r;
  assign out_which_number = outw_r;
  assign out_last         = last_r;

endmodule

### rtl/rnp_checker.sv
// Port-level checker of the Roman numeral block, bound to the top level.
// Depends on rnp_pkg and the assertion macros in the defines header.
`include "roman_numerals_of_value_and_primes_top_defines.svh"

module rnp_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic [rnp_pkg::IN_W-1:0] in_value,
  input logic                     out_strobe,
  input logic [3:0]               out_symbol,
  input logic [1:0]               out_which_number,
  input logic                     out_last
);
  import rnp_pkg::*;

  logic acc_bad, acc_good;

  assign acc_bad  = start && !busy && ((in_value < VAL_MIN) || (in_value > VAL_MAX));
  assign acc_good = start && !busy && !((in_value < VAL_MIN) || (in_value > VAL_MAX));

  // An out-of-range item answers with a lone stop token and the block stays ready.
  `RNP_ASSERT_NEXT(a_stop_token, clk, rst_n, acc_bad, out_strobe && (out_symbol == SYM_STOP) && out_last && !busy, "out-of-range item did not give one stop token")
  // An in-range item occupies the block.
  `RNP_ASSERT_NEXT(a_busy_after_go, clk, rst_n, acc_good, busy, "in-range item did not make the block busy")
  // The final token of an item leaves the block ready.
  `RNP_ASSERT_SAME(a_last_idle, clk, rst_n, out_strobe && out_last, !busy, "final token shown while still busy")
  // Any other token is sent while the item is still in work.
  `RNP_ASSERT_SAME(a_mid_busy, clk, rst_n, out_strobe && !out_last, busy && (out_symbol != SYM_STOP), "non-final token outside an item")

endmodule

bind roman_numerals_of_value_and_primes_top rnp_checker u_rnp_checker (.*);
